// ===== sv/uqt_pkg.sv =====
// shared types, codes and helpers for the url query tokenizer
package uqt_pkg;

   // input transaction payload
   typedef struct packed {
      logic       action;
      logic [7:0] in_byte;
   } req_type;

   // result transaction payload
   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] out_char;
      logic       query_end;
   } rsp_type;

   // input action codes
   localparam logic ACT_BYTE = 1'b0;
   localparam logic ACT_END  = 1'b1;

   // result kind codes
   localparam logic [2:0] KIND_KEY_CHAR = 3'd0;
   localparam logic [2:0] KIND_VAL_CHAR = 3'd1;
   localparam logic [2:0] KIND_UNNAMED  = 3'd2;
   localparam logic [2:0] KIND_PAIR     = 3'd3;
   localparam logic [2:0] KIND_NONE     = 3'd4;

   // parser modes
   typedef enum logic [1:0] {
      MODE_KEY     = 2'd0,
      MODE_VAL     = 2'd1,
      MODE_KEY_ESC = 2'd2,
      MODE_VAL_ESC = 2'd3
   } mode_type;

   // parser state carried between transactions
   typedef struct packed {
      mode_type   mode;
      logic       digit_seen;
      logic [3:0] first_nib;
      logic       key_has;
   } state_type;

   // special bytes
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_AMP     = 8'h26;
   localparam logic [7:0] CH_SEMI    = 8'h3B;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_EQUAL   = 8'h3D;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_LOW_A   = 8'h61;
   localparam logic [7:0] CH_LOW_Z   = 8'h7A;
   localparam logic [7:0] CASE_DIFF  = 8'h20;
   localparam logic [7:0] HEX_BIAS   = 8'd55;

   // escape digit value, no hex check, wraps modulo 256
   function automatic logic [7:0] nibble_of(input logic [7:0] b);
      logic [7:0] c;
      c = b;
      if (b >= CH_ZERO && b <= CH_NINE) begin
         return b - CH_ZERO;
      end
      if (b >= CH_LOW_A && b <= CH_LOW_Z) begin
         c = b - CASE_DIFF;
      end
      return c - HEX_BIAS;
   endfunction

endpackage

// ===== sv/uqt_step.sv =====
// one parser step: next state and result for one query transaction
module uqt_step (
   input  uqt_pkg::state_type st,
   input  uqt_pkg::req_type   item,
   output uqt_pkg::state_type st_next,
   output logic               res_valid,
   output uqt_pkg::rsp_type   res
);

   logic       in_key;
   logic [7:0] nib;
   logic [7:0] esc_char;
   logic       is_sep;

   // shared decode of the byte
   always_comb begin
      in_key   = (st.mode == uqt_pkg::MODE_KEY) || (st.mode == uqt_pkg::MODE_KEY_ESC);
      nib      = uqt_pkg::nibble_of(item.in_byte);
      esc_char = {st.first_nib, 4'b0000} + nib;
      is_sep   = (item.in_byte == uqt_pkg::CH_AMP) || (item.in_byte == uqt_pkg::CH_SEMI);
   end

   // next state
   always_comb begin
      st_next = st;
      if (item.action == uqt_pkg::ACT_END) begin
         st_next.mode       = uqt_pkg::MODE_KEY;
         st_next.digit_seen = 1'b0;
         st_next.first_nib  = 4'd0;
         st_next.key_has    = 1'b0;
      end else begin
         unique case (st.mode)
            uqt_pkg::MODE_KEY_ESC, uqt_pkg::MODE_VAL_ESC: begin
               if (!st.digit_seen) begin
                  st_next.digit_seen = 1'b1;
                  st_next.first_nib  = nib[3:0];
               end else begin
                  st_next.digit_seen = 1'b0;
                  st_next.first_nib  = 4'd0;
                  st_next.mode       = in_key ? uqt_pkg::MODE_KEY : uqt_pkg::MODE_VAL;
                  if (in_key) begin
                     st_next.key_has = 1'b1;
                  end
               end
            end
            uqt_pkg::MODE_KEY, uqt_pkg::MODE_VAL: begin
               priority if (item.in_byte == uqt_pkg::CH_PERCENT) begin
                  st_next.digit_seen = 1'b0;
                  st_next.first_nib  = 4'd0;
                  st_next.mode = in_key ? uqt_pkg::MODE_KEY_ESC : uqt_pkg::MODE_VAL_ESC;
               end else if (is_sep) begin
                  st_next.key_has = 1'b0;
                  st_next.mode    = uqt_pkg::MODE_KEY;
               end else if (item.in_byte == uqt_pkg::CH_EQUAL && in_key) begin
                  st_next.mode = uqt_pkg::MODE_VAL;
               end else if (in_key) begin
                  st_next.key_has = 1'b1;
               end else begin
                  st_next.key_has = st.key_has;
               end
            end
            default: begin
               st_next = st;
            end
         endcase
      end
   end

   // result
   always_comb begin
      res_valid     = 1'b0;
      res.kind      = uqt_pkg::KIND_NONE;
      res.out_char  = 8'd0;
      res.query_end = 1'b0;
      if (item.action == uqt_pkg::ACT_END) begin
         res_valid     = 1'b1;
         res.query_end = 1'b1;
         if (in_key) begin
            res.kind = st.key_has ? uqt_pkg::KIND_UNNAMED : uqt_pkg::KIND_NONE;
         end else begin
            res.kind = uqt_pkg::KIND_PAIR;
         end
      end else begin
         unique case (st.mode)
            uqt_pkg::MODE_KEY_ESC, uqt_pkg::MODE_VAL_ESC: begin
               if (st.digit_seen) begin
                  res_valid    = 1'b1;
                  res.kind     = in_key ? uqt_pkg::KIND_KEY_CHAR : uqt_pkg::KIND_VAL_CHAR;
                  res.out_char = esc_char;
               end
            end
            uqt_pkg::MODE_KEY, uqt_pkg::MODE_VAL: begin
               priority if (item.in_byte == uqt_pkg::CH_PERCENT) begin
                  res_valid = 1'b0;
               end else if (is_sep) begin
                  res_valid = 1'b1;
                  res.kind  = in_key ? uqt_pkg::KIND_UNNAMED : uqt_pkg::KIND_PAIR;
               end else if (item.in_byte == uqt_pkg::CH_EQUAL && in_key) begin
                  res_valid = 1'b0;
               end else begin
                  res_valid    = 1'b1;
                  res.kind     = in_key ? uqt_pkg::KIND_KEY_CHAR : uqt_pkg::KIND_VAL_CHAR;
                  res.out_char = (item.in_byte == uqt_pkg::CH_PLUS) ? uqt_pkg::CH_SPACE
                                                                    : item.in_byte;
               end
            end
            default: begin
               res_valid = 1'b0;
            end
         endcase
      end
   end

endmodule

// ===== sv/url_query_tokenizer.sv =====
// url query tokenizer top level: input register, parser step, result register
//
// Takes one query byte (or an end-of-query mark) per transaction and returns at
// most one result: a decoded key or value character, an unnamed-key or pair
// event, or on end of query a flush report. Throughput is one transaction per
// clock unless the result side stalls. An accepted transaction is held in the
// input register, passes through a single step of the parser and lands in the
// result register, where rsp_valid rises. The parser state updates in the same
// cycle the registered item is consumed, so each item sees the state its
// predecessor left. If the result side stalls, one more item is held in the input
// register before req_ready drops. No clearing pass is needed after reset.
module url_query_tokenizer (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  uqt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output uqt_pkg::rsp_type rsp_data
);

   logic               in_valid_ff;
   logic               in_valid_in;
   uqt_pkg::req_type   in_data_ff;
   uqt_pkg::state_type st_ff;
   uqt_pkg::state_type st_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   uqt_pkg::rsp_type   rsp_data_ff;
   uqt_pkg::state_type step_next;
   logic               step_res_valid;
   uqt_pkg::rsp_type   step_res;
   logic               proceed;
   logic               req_fire;

   // parser step
   uqt_step u_step (
      .st        (st_ff),
      .item      (in_data_ff),
      .st_next   (step_next),
      .res_valid (step_res_valid),
      .res       (step_res)
   );

   // flow control
   always_comb begin
      proceed   = in_valid_ff && (!step_res_valid || !rsp_valid_ff || rsp_ready);
      req_ready = !in_valid_ff || proceed;
      req_fire  = req_valid && req_ready;
   end

   // next values
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (proceed) begin
         in_valid_in = 1'b0;
      end
      st_in = proceed ? step_next : st_ff;
      rsp_valid_in = rsp_valid_ff;
      if (proceed && step_res_valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         st_ff.mode       <= uqt_pkg::MODE_KEY;
         st_ff.digit_seen <= 1'b0;
         st_ff.first_nib  <= 4'd0;
         st_ff.key_has    <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         st_ff        <= st_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_data_ff <= req_data;
      end
      if (proceed && step_res_valid) begin
         rsp_data_ff <= step_res;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // an end-of-query transaction leaves the parser in its reset state
   a_end_resets: assert property (@(posedge clock) disable iff (reset)
      (proceed && in_data_ff.action == uqt_pkg::ACT_END) |=>
      (st_ff.mode == uqt_pkg::MODE_KEY && !st_ff.digit_seen && !st_ff.key_has))
      else $error("end of query did not reset parser state");

   // a pending escape digit exists only in an escape mode
   a_digit_in_esc: assert property (@(posedge clock) disable iff (reset)
      st_ff.digit_seen |->
      (st_ff.mode == uqt_pkg::MODE_KEY_ESC || st_ff.mode == uqt_pkg::MODE_VAL_ESC))
      else $error("escape digit pending outside escape mode");

   // emitting a key character marks the key as non-empty
   a_key_marked: assert property (@(posedge clock) disable iff (reset)
      (proceed && step_res_valid && step_res.kind == uqt_pkg::KIND_KEY_CHAR) |=>
      st_ff.key_has)
      else $error("key char emitted without marking key");

   // end reports are events only, never characters
   a_end_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.query_end) |->
      ((rsp_data_ff.kind == uqt_pkg::KIND_UNNAMED || rsp_data_ff.kind == uqt_pkg::KIND_PAIR
        || rsp_data_ff.kind == uqt_pkg::KIND_NONE) && rsp_data_ff.out_char == 8'd0))
      else $error("end of query result carries a character");

   // a held result is not overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !(proceed && step_res_valid))
      else $error("result register overwritten while stalled");

endmodule

// ===== verif/url_query_tokenizer_tb.sv =====
// self-checking testbench for the url query tokenizer: directed vectors, random queries
`timescale 1ns / 100ps

module url_query_tokenizer_tb;

   localparam int CLOCK_PERIOD = 8;
   localparam int RESET_CYCLES = 11;
   localparam int RANDOM_ITEMS = 1800;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 12;
   localparam int GAP_PERCENT  = 24;
   localparam int MAX_PRINTED  = 40;

   // one directed stimulus row, with an optional hand-written expected result
   typedef struct {
      uqt_pkg::req_type item;
      bit               typed;
      uqt_pkg::rsp_type want;
   } vector_row_type;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   uqt_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   uqt_pkg::rsp_type rsp_data;

   // shadow copy of the parser state
   uqt_pkg::mode_type tok_mode       = uqt_pkg::MODE_KEY;
   logic              tok_digit_seen = 1'b0;
   logic [7:0]        tok_first_nib  = '0;
   logic              tok_key_has    = 1'b0;

   uqt_pkg::rsp_type pending_tokens_q[$];
   uqt_pkg::req_type burst_q[$];
   vector_row_type   vectors[$];
   uqt_pkg::rsp_type want_rsp;
   string            hex_chars = "0123456789abcdefABCDEF";

   bit gaps_on      = 1'b1;
   int err_count    = 0;
   int cycle_count  = 0;
   int items_sent   = 0;
   int ends_sent    = 0;
   int results_seen = 0;
   int kind_seen [5];

   url_query_tokenizer u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input int want_v, input int got_v);
      err_count++;
      if (err_count <= MAX_PRINTED) begin
         $display("ERROR cycle %0d: %s: expected 0x%0h, got 0x%0h",
                  cycle_count, what, want_v, got_v);
      end
   endtask

   // escape digit value: digits map directly, letters fold to upper case, no hex check
   function automatic logic [7:0] escape_digit(input logic [7:0] b);
      logic [7:0] c;
      if (b >= uqt_pkg::CH_ZERO && b <= uqt_pkg::CH_NINE) begin
         return b - uqt_pkg::CH_ZERO;
      end
      c = (b >= uqt_pkg::CH_LOW_A && b <= uqt_pkg::CH_LOW_Z) ? b - uqt_pkg::CASE_DIFF : b;
      return c - uqt_pkg::HEX_BIAS;
   endfunction

   function automatic void clear_parser();
      tok_mode       = uqt_pkg::MODE_KEY;
      tok_digit_seen = 1'b0;
      tok_first_nib  = '0;
      tok_key_has    = 1'b0;
   endfunction

   // advance the shadow parser by one transaction; returns 1 when a token comes out
   function automatic bit tokenize_step(input uqt_pkg::req_type it,
                                        output uqt_pkg::rsp_type res);
      logic [7:0] nib;
      logic       in_key;
      res    = '0;
      in_key = (tok_mode == uqt_pkg::MODE_KEY || tok_mode == uqt_pkg::MODE_KEY_ESC);
      if (it.action == uqt_pkg::ACT_END) begin
         if (!in_key) begin
            res.kind = uqt_pkg::KIND_PAIR;
         end else if (tok_key_has) begin
            res.kind = uqt_pkg::KIND_UNNAMED;
         end else begin
            res.kind = uqt_pkg::KIND_NONE;
         end
         res.query_end = 1'b1;
         clear_parser();
         return 1'b1;
      end
      if (tok_mode == uqt_pkg::MODE_KEY_ESC || tok_mode == uqt_pkg::MODE_VAL_ESC) begin
         nib = escape_digit(it.in_byte);
         if (!tok_digit_seen) begin
            tok_first_nib  = nib;
            tok_digit_seen = 1'b1;
            return 1'b0;
         end
         // only the low nibble of the first digit survives the shift
         res.out_char   = {tok_first_nib[3:0], 4'h0} + nib;
         tok_digit_seen = 1'b0;
         tok_first_nib  = '0;
         tok_mode       = in_key ? uqt_pkg::MODE_KEY : uqt_pkg::MODE_VAL;
      end else begin
         case (it.in_byte)
            uqt_pkg::CH_PERCENT: begin
               tok_digit_seen = 1'b0;
               tok_first_nib  = '0;
               tok_mode       = in_key ? uqt_pkg::MODE_KEY_ESC : uqt_pkg::MODE_VAL_ESC;
               return 1'b0;
            end
            uqt_pkg::CH_AMP, uqt_pkg::CH_SEMI: begin
               tok_key_has = 1'b0;
               tok_mode    = uqt_pkg::MODE_KEY;
               res.kind    = in_key ? uqt_pkg::KIND_UNNAMED : uqt_pkg::KIND_PAIR;
               return 1'b1;
            end
            uqt_pkg::CH_EQUAL: begin
               if (in_key) begin
                  tok_mode = uqt_pkg::MODE_VAL;
                  return 1'b0;
               end
               res.out_char = it.in_byte;
            end
            uqt_pkg::CH_PLUS: res.out_char = uqt_pkg::CH_SPACE;
            default: res.out_char = it.in_byte;
         endcase
      end
      res.kind = in_key ? uqt_pkg::KIND_KEY_CHAR : uqt_pkg::KIND_VAL_CHAR;
      if (in_key) begin
         tok_key_has = 1'b1;
      end
      return 1'b1;
   endfunction

   // drive one transaction; called and returns at a falling edge
   task automatic send_item(input uqt_pkg::req_type it, input bit typed,
                            input uqt_pkg::rsp_type want);
      uqt_pkg::rsp_type pred;
      bit               has_token;
      if (gaps_on && $urandom_range(99) < GAP_PERCENT) begin
         req_valid <= 1'b0;
         do @(negedge clock); while (gaps_on && $urandom_range(99) < GAP_PERCENT);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      has_token = tokenize_step(it, pred);
      if (typed) begin
         pred = want;
      end
      if (has_token || typed) begin
         pending_tokens_q = {pending_tokens_q, pred};
      end
      items_sent++;
      if (it.action == uqt_pkg::ACT_END) begin
         ends_sent++;
      end
      @(negedge clock);
   endtask

   // sender holds off until every expected token has come back
   task automatic drain_pause();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_tokens_q.size() != 0);
   endtask

   task automatic add_vector(input logic act, input logic [7:0] b, input bit typed,
                             input uqt_pkg::rsp_type want);
      vector_row_type row;
      row.item  = {act, b};
      row.typed = typed;
      row.want  = want;
      vectors   = {vectors, row};
   endtask

   task automatic queue_item(input logic act, input logic [7:0] b);
      uqt_pkg::req_type it;
      it.action  = act;
      it.in_byte = b;
      burst_q    = {burst_q, it};
   endtask

   task automatic put_byte(input logic [7:0] b);
      queue_item(uqt_pkg::ACT_BYTE, b);
   endtask

   // one decoded character in raw form: plain, plus, hex escape or junk escape
   task automatic put_text_char(input bit in_value);
      int         r;
      logic [7:0] b;
      r = $urandom_range(99);
      if (in_value && r < 6) begin
         put_byte(uqt_pkg::CH_EQUAL);
      end else if (r < 60) begin
         b = 8'($urandom_range(255));
         if (b == uqt_pkg::CH_PERCENT || b == uqt_pkg::CH_AMP || b == uqt_pkg::CH_SEMI ||
             b == uqt_pkg::CH_PLUS || b == uqt_pkg::CH_EQUAL) begin
            b = uqt_pkg::CH_LOW_A + 8'($urandom_range(25));
         end
         put_byte(b);
      end else if (r < 70) begin
         put_byte(uqt_pkg::CH_PLUS);
      end else if (r < 90) begin
         put_byte(uqt_pkg::CH_PERCENT);
         put_byte(hex_chars[$urandom_range(21)]);
         put_byte(hex_chars[$urandom_range(21)]);
      end else begin
         put_byte(uqt_pkg::CH_PERCENT);
         put_byte(8'($urandom_range(255)));
         put_byte(8'($urandom_range(255)));
      end
   endtask

   // a well-formed query with random content, sometimes cut mid-escape or left without an end mark
   task automatic build_query();
      int pairs;
      int klen;
      int vlen;
      int r;
      pairs = $urandom_range(1, 5);
      for (int p = 0; p < pairs; p++) begin
         if (p != 0) begin
            put_byte($urandom_range(1) ? uqt_pkg::CH_AMP : uqt_pkg::CH_SEMI);
         end
         klen = $urandom_range(0, 5);
         for (int k = 0; k < klen; k++) put_text_char(1'b0);
         if ($urandom_range(99) < 80) begin
            put_byte(uqt_pkg::CH_EQUAL);
            vlen = $urandom_range(0, 6);
            for (int v = 0; v < vlen; v++) put_text_char(1'b1);
         end
      end
      r = $urandom_range(99);
      if (r < 10) begin
         put_byte(uqt_pkg::CH_PERCENT);
         if ($urandom_range(1)) begin
            put_byte(hex_chars[$urandom_range(21)]);
         end
      end
      if (r < 95) begin
         queue_item(uqt_pkg::ACT_END, 8'($urandom_range(255)));
      end
   endtask

   // result side stalls at random
   always @(negedge clock) begin
      rsp_ready <= !(gaps_on && $urandom_range(99) < GAP_PERCENT);
   end

   // compare each result transaction with the oldest expected token
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (rsp_data.kind <= uqt_pkg::KIND_NONE) begin
            kind_seen[rsp_data.kind]++;
         end
         if (pending_tokens_q.size() == 0) begin
            report_mismatch("result with nothing pending", 0, int'(rsp_data));
         end else begin
            want_rsp = pending_tokens_q.pop_front();
            if (rsp_data.kind != want_rsp.kind) begin
               report_mismatch("kind", int'(want_rsp.kind), int'(rsp_data.kind));
            end
            if (rsp_data.out_char != want_rsp.out_char) begin
               report_mismatch("out_char", int'(want_rsp.out_char), int'(rsp_data.out_char));
            end
            if (rsp_data.query_end != want_rsp.query_end) begin
               report_mismatch("query_end", int'(want_rsp.query_end),
                               int'(rsp_data.query_end));
            end
         end
      end
   end

   initial begin
      int random_sent;
      int n;
      random_sent = 0;

      // directed vectors
      add_vector(uqt_pkg::ACT_END,  8'hFF, 1'b1,
                 {uqt_pkg::KIND_NONE, 8'h00, 1'b1});                    // end at reset, byte ignored
      add_vector(uqt_pkg::ACT_BYTE, uqt_pkg::CH_AMP, 1'b1,
                 {uqt_pkg::KIND_UNNAMED, 8'h00, 1'b0});                 // empty unnamed key
      add_vector(uqt_pkg::ACT_BYTE, 8'h00, 1'b1, {uqt_pkg::KIND_KEY_CHAR, 8'h00, 1'b0});
      add_vector(uqt_pkg::ACT_BYTE, uqt_pkg::CH_PLUS, 1'b1,
                 {uqt_pkg::KIND_KEY_CHAR, uqt_pkg::CH_SPACE, 1'b0});
      add_vector(uqt_pkg::ACT_BYTE, 8'hFF, 1'b1, {uqt_pkg::KIND_KEY_CHAR, 8'hFF, 1'b0});
      add_vector(uqt_pkg::ACT_BYTE, uqt_pkg::CH_EQUAL,   1'b0, '0);   // into value
      add_vector(uqt_pkg::ACT_BYTE, uqt_pkg::CH_EQUAL,   1'b0, '0);   // second '=' is data
      add_vector(uqt_pkg::ACT_BYTE, uqt_pkg::CH_PLUS, 1'b1,
                 {uqt_pkg::KIND_VAL_CHAR, uqt_pkg::CH_SPACE, 1'b0});
      add_vector(uqt_pkg::ACT_BYTE, uqt_pkg::CH_PERCENT, 1'b0, '0);
      add_vector(uqt_pkg::ACT_BYTE, 8'h34,               1'b0, '0);   // '4'
      add_vector(uqt_pkg::ACT_BYTE, 8'h65,               1'b0, '0);   // 'e', lower-case hex
      add_vector(uqt_pkg::ACT_BYTE, uqt_pkg::CH_SEMI, 1'b1,
                 {uqt_pkg::KIND_PAIR, 8'h00, 1'b0});
      add_vector(uqt_pkg::ACT_BYTE, uqt_pkg::CH_PERCENT, 1'b0, '0);
      add_vector(uqt_pkg::ACT_BYTE, 8'h66,               1'b0, '0);   // 'f'
      add_vector(uqt_pkg::ACT_BYTE, 8'h46,               1'b0, '0);   // 'F'
      add_vector(uqt_pkg::ACT_BYTE, uqt_pkg::CH_PERCENT, 1'b0, '0);   // non-hex digits wrap
      add_vector(uqt_pkg::ACT_BYTE, 8'hFF,               1'b0, '0);
      add_vector(uqt_pkg::ACT_BYTE, 8'h00,               1'b0, '0);
      add_vector(uqt_pkg::ACT_BYTE, uqt_pkg::CH_PERCENT, 1'b0, '0);   // partial key escape
      add_vector(uqt_pkg::ACT_BYTE, 8'h5A,               1'b0, '0);
      add_vector(uqt_pkg::ACT_END,  8'h00, 1'b1, {uqt_pkg::KIND_UNNAMED, 8'h00, 1'b1});
      add_vector(uqt_pkg::ACT_BYTE, uqt_pkg::CH_EQUAL,   1'b0, '0);   // partial value escape
      add_vector(uqt_pkg::ACT_BYTE, uqt_pkg::CH_PERCENT, 1'b0, '0);
      add_vector(uqt_pkg::ACT_END,  8'h00, 1'b1, {uqt_pkg::KIND_PAIR, 8'h00, 1'b1});
      add_vector(uqt_pkg::ACT_END,  8'h00, 1'b1, {uqt_pkg::KIND_NONE, 8'h00, 1'b1});

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      clear_parser();

      foreach (vectors[i]) begin
         send_item(vectors[i].item, vectors[i].typed, vectors[i].want);
      end
      drain_pause();

      // random queries mixed with noise
      while (random_sent < RANDOM_ITEMS) begin
         burst_q.delete();
         if ($urandom_range(99) < 12) begin
            n = $urandom_range(1, 8);
            repeat (n) begin
               queue_item(($urandom_range(7) == 0) ? uqt_pkg::ACT_END : uqt_pkg::ACT_BYTE,
                          8'($urandom_range(255)));
            end
         end else begin
            build_query();
         end
         foreach (burst_q[i]) begin
            gaps_on = !(random_sent >= 700 && random_sent < 1100);
            send_item(burst_q[i], 1'b0, '0);
            random_sent++;
            if (random_sent == 900) begin
               drain_pause();
            end
         end
      end
      gaps_on = 1'b1;
      req_valid <= 1'b0;

      // wait for outstanding tokens, then a drain period for anything stray
      while (pending_tokens_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d transactions (%0d end-of-query), checked %0d results",
               items_sent, ends_sent, results_seen);
      $display("token kinds: key %0d, value %0d, unnamed %0d, pair %0d, none %0d",
               kind_seen[uqt_pkg::KIND_KEY_CHAR], kind_seen[uqt_pkg::KIND_VAL_CHAR],
               kind_seen[uqt_pkg::KIND_UNNAMED], kind_seen[uqt_pkg::KIND_PAIR],
               kind_seen[uqt_pkg::KIND_NONE]);
      if (err_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/uqt_pkg.sv
sv/uqt_step.sv
sv/url_query_tokenizer.sv
verif/url_query_tokenizer_tb.sv
